[rtl/olpd_pkg.sv]
// Shared types, constants and helpers for the opcode/length packet deframer.
package olpd_pkg;

    localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd2048;
    localparam logic        HS_ENABLE_RESET   = 1'b1;

    localparam logic CFG_MAX_PAYLOAD = 1'b0;
    localparam logic CFG_HS_ENABLE   = 1'b1;

    localparam logic [1:0] KIND_PAYLOAD   = 2'd0;
    localparam logic [1:0] KIND_EMPTY     = 2'd1;
    localparam logic [1:0] KIND_BAD_OP    = 2'd2;
    localparam logic [1:0] KIND_TOO_LARGE = 2'd3;

    localparam logic [6:0] OP_HS_START = 7'h01;
    localparam logic [6:0] OP_HS_BODY  = 7'h50;
    localparam logic [7:0] HS_LEN_HI   = 8'hFF;
    localparam logic [7:0] HS_LEN_LO   = 8'h50;
    localparam logic [15:0] HS_REST    = 16'd46;

    typedef struct packed {
        logic [1:0] kind;
        logic [6:0] opcode;
        logic [7:0] data;
        logic       first;
        logic       last;
        logic       dual;   // second handshake byte follows this result
    } cmd_t;

    function automatic logic [6:0] fixed_body_size(input logic [6:0] op);
        case (op)
            7'h50:   fixed_body_size = 7'd48;
            7'h51:   fixed_body_size = 7'd32;
            7'h09:   fixed_body_size = 7'd4;
            7'h53:   fixed_body_size = 7'd72;
            7'h54:   fixed_body_size = 7'd20;
            default: fixed_body_size = 7'd0;
        endcase
    endfunction

endpackage

[rtl/olpd_front.sv]
// Front end: byte classification, framing state and configuration registers.
module olpd_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  logic [7:0]     rx_byte,
    input  logic           q_full,
    input  logic           cfg_write,
    input  logic           cfg_index,
    input  logic [15:0]    cfg_data,
    output logic           q_push,
    output olpd_pkg::cmd_t q_cmd
);
    import olpd_pkg::*;

    localparam logic [2:0] PH_IDLE       = 3'd0;
    localparam logic [2:0] PH_LEN_HI     = 3'd1;
    localparam logic [2:0] PH_LEN_LO     = 3'd2;
    localparam logic [2:0] PH_BODY_FIRST = 3'd3;
    localparam logic [2:0] PH_BODY_REST  = 3'd4;

    logic [15:0] max_payload_reg;
    logic        hs_enable_reg;
    logic [2:0]  phase_reg, phase_next;
    logic [6:0]  opcode_reg, opcode_next;
    logic [7:0]  held_reg, held_next;
    logic [15:0] remaining_reg, remaining_next;
    logic        closed_reg, closed_next;
    logic        accept;

    assign accept = push && !q_full;

    always_comb
    begin
        logic [15:0] len;
        logic [15:0] rem_eff;
        logic [15:0] rem_dec;
        logic [6:0]  size;
        len            = {held_reg, rx_byte};
        rem_eff        = (remaining_reg == 16'd0) ? 16'd1 : remaining_reg;
        rem_dec        = rem_eff - 16'd1;
        size           = fixed_body_size(rx_byte[6:0]);
        phase_next     = phase_reg;
        opcode_next    = opcode_reg;
        held_next      = held_reg;
        remaining_next = remaining_reg;
        closed_next    = closed_reg;
        q_push         = 1'b0;
        q_cmd          = '0;
        if (accept && !closed_reg)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (rx_byte == 8'd0 || rx_byte[7])
                    begin
                        q_push      = 1'b1;
                        q_cmd.kind  = KIND_BAD_OP;
                        q_cmd.last  = 1'b1;
                        closed_next = 1'b1;
                    end
                    else
                    begin
                        opcode_next = rx_byte[6:0];
                        if (size != 7'd0)
                        begin
                            remaining_next = {9'd0, size};
                            phase_next     = PH_BODY_FIRST;
                        end
                        else
                        begin
                            phase_next = PH_LEN_HI;
                        end
                    end
                end
                PH_LEN_HI:
                begin
                    held_next  = rx_byte;
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    if (hs_enable_reg && opcode_reg == OP_HS_START
                        && held_reg == HS_LEN_HI && rx_byte == HS_LEN_LO)
                    begin
                        opcode_next    = OP_HS_BODY;
                        q_push         = 1'b1;
                        q_cmd.kind     = KIND_PAYLOAD;
                        q_cmd.opcode   = OP_HS_BODY;
                        q_cmd.data     = HS_LEN_HI;
                        q_cmd.first    = 1'b1;
                        q_cmd.dual     = 1'b1;
                        remaining_next = HS_REST;
                        phase_next     = PH_BODY_REST;
                    end
                    else if (len == 16'd0)
                    begin
                        q_push       = 1'b1;
                        q_cmd.kind   = KIND_EMPTY;
                        q_cmd.opcode = opcode_reg;
                        q_cmd.first  = 1'b1;
                        q_cmd.last   = 1'b1;
                        phase_next   = PH_IDLE;
                    end
                    else if (len > max_payload_reg)
                    begin
                        q_push       = 1'b1;
                        q_cmd.kind   = KIND_TOO_LARGE;
                        q_cmd.opcode = opcode_reg;
                        q_cmd.last   = 1'b1;
                        closed_next  = 1'b1;
                    end
                    else
                    begin
                        remaining_next = len;
                        phase_next     = PH_BODY_FIRST;
                    end
                end
                PH_BODY_FIRST, PH_BODY_REST:
                begin
                    remaining_next = rem_dec;
                    q_push         = 1'b1;
                    q_cmd.kind     = KIND_PAYLOAD;
                    q_cmd.opcode   = opcode_reg;
                    q_cmd.data     = rx_byte;
                    q_cmd.first    = (phase_reg == PH_BODY_FIRST);
                    q_cmd.last     = (rem_dec == 16'd0);
                    phase_next     = (rem_dec == 16'd0) ? PH_IDLE : PH_BODY_REST;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
            hs_enable_reg   <= HS_ENABLE_RESET;
            phase_reg       <= PH_IDLE;
            opcode_reg      <= '0;
            held_reg        <= '0;
            remaining_reg   <= '0;
            closed_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_write && cfg_index == CFG_MAX_PAYLOAD)
                max_payload_reg <= cfg_data;
            if (cfg_write && cfg_index == CFG_HS_ENABLE)
                hs_enable_reg <= cfg_data[0];
            phase_reg     <= phase_next;
            opcode_reg    <= opcode_next;
            held_reg      <= held_next;
            remaining_reg <= remaining_next;
            closed_reg    <= closed_next;
        end
    end

endmodule

[rtl/olpd_queue.sv]
// Short command queue between the front end and the result stage.
module olpd_queue #(
    parameter int unsigned DEPTH = olpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  olpd_pkg::cmd_t wr_cmd,
    input  logic           rd_en,
    output olpd_pkg::cmd_t rd_cmd,
    output logic           not_empty,
    output logic           is_full
);
    import olpd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr, do_rd;

    assign not_empty = (count_reg != '0);
    assign is_full   = (count_reg == FULL_CNT);
    assign rd_cmd    = mem_reg[rd_ptr_reg];
    assign do_wr     = wr_en && !is_full;
    assign do_rd     = rd_en && not_empty;

    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd)
            count_next = count_reg + 1'b1;
        else if (do_rd && !do_wr)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

[rtl/olpd_back.sv]
// Result stage: output register, splits handshake commands into two transfers.
module olpd_back (
    input  logic           clk,
    input  logic           rst_n,
    input  olpd_pkg::cmd_t q_cmd,
    input  logic           q_valid,
    output logic           q_pop,
    input  logic           pop,
    output logic           empty,
    output logic [1:0]     kind,
    output logic [6:0]     packet_opcode,
    output logic [7:0]     data_byte,
    output logic           first_flag,
    output logic           last_flag
);
    import olpd_pkg::*;

    cmd_t out_reg;
    logic valid_reg;
    logic taken;

    assign taken = pop && valid_reg;
    assign q_pop = q_valid && (!valid_reg || (taken && !out_reg.dual));

    assign empty         = !valid_reg;
    assign kind          = out_reg.kind;
    assign packet_opcode = out_reg.opcode;
    assign data_byte     = out_reg.data;
    assign first_flag    = out_reg.first;
    assign last_flag     = out_reg.last;

    always_ff @(posedge clk)
    begin
        if (taken && out_reg.dual)
        begin
            out_reg.data  <= HS_LEN_LO;
            out_reg.first <= 1'b0;
            out_reg.dual  <= 1'b0;
        end
        else if (q_pop)
        begin
            out_reg <= q_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (q_pop)
            valid_reg <= 1'b1;
        else if (taken && !out_reg.dual)
            valid_reg <= 1'b0;
    end

endmodule

[rtl/opcode_length_packet_deframer_top.sv]
// Results pass through the command queue, then the output register.
// One byte per cycle while not full; the handshake length byte yields two transfers.
// Input stalls (full) only when the command queue is full; its depth is QUEUE_DEPTH.
// Reset (rst_n low, async): idle framing state, stream open, queue and output empty,
// max_payload 2048, handshake detection enabled.
module opcode_length_packet_deframer_top #(
    parameter int unsigned QUEUE_DEPTH = olpd_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  kind,
    output logic [6:0]  packet_opcode,
    output logic [7:0]  data_byte,
    output logic        first_flag,
    output logic        last_flag,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);
    import olpd_pkg::*;

    cmd_t wr_cmd;
    cmd_t head_cmd;
    logic wr_en;
    logic head_valid;
    logic head_pop;

    olpd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .rx_byte   (rx_byte),
        .q_full    (full),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (wr_en),
        .q_cmd     (wr_cmd)
    );

    olpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_cmd    (wr_cmd),
        .rd_en     (head_pop),
        .rd_cmd    (head_cmd),
        .not_empty (head_valid),
        .is_full   (full)
    );

    olpd_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_cmd         (head_cmd),
        .q_valid       (head_valid),
        .q_pop         (head_pop),
        .pop           (pop),
        .empty         (empty),
        .kind          (kind),
        .packet_opcode (packet_opcode),
        .data_byte     (data_byte),
        .first_flag    (first_flag),
        .last_flag     (last_flag)
    );

endmodule

[test/tb_opcode_length_packet_deframer_top.sv]
// Testbench for the opcode/length packet deframer: byte stimulus, predicted results, checks.
module tb_opcode_length_packet_deframer_top;
    import olpd_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 8;

    typedef enum logic [2:0] {
        AWAIT_OPCODE,
        AWAIT_LEN_HI,
        AWAIT_LEN_LO,
        BODY_HEAD,
        BODY_TAIL
    } deframe_phase_t;

    typedef struct {
        logic [1:0] kind;
        logic [6:0] opcode;
        logic [7:0] data;
        logic       first;
        logic       last;
    } frame_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic [7:0]  rx_byte = 8'd0;
    logic        empty;
    logic        pop = 1'b0;
    logic [1:0]  kind;
    logic [6:0]  packet_opcode;
    logic [7:0]  data_byte;
    logic        first_flag;
    logic        last_flag;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [15:0] cfg_data = 16'd0;

    opcode_length_packet_deframer_top uut (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .rx_byte(rx_byte),
        .empty(empty),
        .pop(pop),
        .kind(kind),
        .packet_opcode(packet_opcode),
        .data_byte(data_byte),
        .first_flag(first_flag),
        .last_flag(last_flag),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predictor state
    deframe_phase_t frame_phase = AWAIT_OPCODE;
    logic [6:0]     frame_opcode = 7'd0;
    logic [7:0]     len_hi_byte = 8'd0;
    logic [15:0]    body_left = 16'd0;
    logic           stream_dead = 1'b0;
    logic [15:0]    max_len_cfg = MAX_PAYLOAD_RESET;
    logic           hs_cfg = HS_ENABLE_RESET;

    frame_result_t pending_results[$];

    int mismatches = 0;
    int bytes_sent = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;
    int quiet_cycles = 0;

    function automatic void expect_result(input logic [1:0] k, input logic [6:0] op,
                                          input logic [7:0] d, input logic f, input logic l);
        frame_result_t r;
        r.kind = k;
        r.opcode = op;
        r.data = d;
        r.first = f;
        r.last = l;
        pending_results.push_back(r);
    endfunction

    function automatic void deframe_byte(input logic [7:0] b);
        logic [15:0] len;
        logic        is_first;
        logic        is_last;
        len = {len_hi_byte, b};
        if (stream_dead)
            return;
        case (frame_phase)
            AWAIT_OPCODE:
            begin
                if (b == 8'h00 || b[7])
                begin
                    expect_result(KIND_BAD_OP, 7'd0, 8'd0, 1'b0, 1'b1);
                    stream_dead = 1'b1;
                end
                else
                begin
                    frame_opcode = b[6:0];
                    case (b[6:0])
                        7'h50:   body_left = 16'd48;
                        7'h51:   body_left = 16'd32;
                        7'h09:   body_left = 16'd4;
                        7'h53:   body_left = 16'd72;
                        7'h54:   body_left = 16'd20;
                        default: body_left = 16'd0;
                    endcase
                    frame_phase = (body_left != 16'd0) ? BODY_HEAD : AWAIT_LEN_HI;
                end
            end
            AWAIT_LEN_HI:
            begin
                len_hi_byte = b;
                frame_phase = AWAIT_LEN_LO;
            end
            AWAIT_LEN_LO:
            begin
                if (hs_cfg && frame_opcode == OP_HS_START && len_hi_byte == HS_LEN_HI
                    && b == HS_LEN_LO)
                begin
                    frame_opcode = OP_HS_BODY;
                    expect_result(KIND_PAYLOAD, OP_HS_BODY, HS_LEN_HI, 1'b1, 1'b0);
                    expect_result(KIND_PAYLOAD, OP_HS_BODY, HS_LEN_LO, 1'b0, 1'b0);
                    body_left = HS_REST;
                    frame_phase = BODY_TAIL;
                end
                else if (len == 16'd0)
                begin
                    expect_result(KIND_EMPTY, frame_opcode, 8'd0, 1'b1, 1'b1);
                    frame_phase = AWAIT_OPCODE;
                end
                else if (len > max_len_cfg)
                begin
                    expect_result(KIND_TOO_LARGE, frame_opcode, 8'd0, 1'b0, 1'b1);
                    stream_dead = 1'b1;
                end
                else
                begin
                    body_left = len;
                    frame_phase = BODY_HEAD;
                end
            end
            BODY_HEAD, BODY_TAIL:
            begin
                is_first = (frame_phase == BODY_HEAD);
                if (body_left == 16'd0)
                    body_left = 16'd1;
                body_left = body_left - 16'd1;
                is_last = (body_left == 16'd0);
                expect_result(KIND_PAYLOAD, frame_opcode, b, is_first, is_last);
                frame_phase = is_last ? AWAIT_OPCODE : BODY_TAIL;
            end
            default:
                frame_phase = AWAIT_OPCODE;
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < 40)
            $display("mismatch at %0t: %s", $realtime, msg);
        mismatches++;
    endtask

    // result side: checks each transfer, then decides pop for the next edge
    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n)
        begin
            if (pop && !empty)
            begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result kind %0d op %h data %h",
                                              kind, packet_opcode, data_byte));
                else
                begin
                    want = pending_results.pop_front();
                    if (kind !== want.kind)
                        report_mismatch($sformatf("kind %0d, want %0d", kind, want.kind));
                    if (packet_opcode !== want.opcode)
                        report_mismatch($sformatf("opcode %h, want %h",
                                                  packet_opcode, want.opcode));
                    if (data_byte !== want.data)
                        report_mismatch($sformatf("data %h, want %h", data_byte, want.data));
                    if (first_flag !== want.first)
                        report_mismatch($sformatf("first %b, want %b",
                                                  first_flag, want.first));
                    if (last_flag !== want.last)
                        report_mismatch($sformatf("last %b, want %b", last_flag, want.last));
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                pop <= 1'b0;
            end
            else
                pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("[opcode_length_packet_deframer_top] ERROR");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        deframe_byte(b);
        bytes_sent++;
    endtask

    task automatic finish_packet();
        while (frame_phase != AWAIT_OPCODE && !stream_dead)
            send_byte(8'($urandom_range(255)));
    endtask

    task automatic send_var_packet(input logic [6:0] op, input logic [15:0] len);
        send_byte({1'b0, op});
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        finish_packet();
    endtask

    task automatic send_handshake();
        send_byte({1'b0, OP_HS_START});
        send_byte(HS_LEN_HI);
        send_byte(HS_LEN_LO);
        finish_packet();
    endtask

    task automatic quiesce();
        push <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_config(input logic [15:0] max_len, input logic hs_on);
        quiesce();
        cfg_write <= 1'b1;
        cfg_index <= CFG_MAX_PAYLOAD;
        cfg_data <= max_len;
        @(posedge clk);
        max_len_cfg = max_len;
        cfg_index <= CFG_HS_ENABLE;
        cfg_data <= {15'd0, hs_on};
        @(posedge clk);
        hs_cfg = hs_on;
        cfg_write <= 1'b0;
    endtask

    task automatic send_random_packet();
        logic [6:0]  op;
        logic [15:0] len;
        int          r;
        int          rl;
        r = $urandom_range(99);
        rl = $urandom_range(99);
        if (r < 10 && hs_cfg)
        begin
            send_handshake();
            return;
        end
        if (r < 20)
            op = OP_HS_START;
        else if (r < 25)
            op = 7'h0A;
        else if (r < 35)
        begin
            case ($urandom_range(4))
                0:       op = 7'h50;
                1:       op = 7'h51;
                2:       op = 7'h09;
                3:       op = 7'h53;
                default: op = 7'h54;
            endcase
        end
        else
            op = 7'($urandom_range(1, 127));
        send_byte({1'b0, op});
        if (frame_phase == AWAIT_LEN_HI)
        begin
            if (rl < 55)
                len = 16'($urandom_range(0, 8));
            else if (rl < 93)
                len = 16'($urandom_range(9, 64));
            else
                len = 16'($urandom_range(65, 300));
            if (len > max_len_cfg)
                len = max_len_cfg;
            send_byte(len[15:8]);
            send_byte(len[7:0]);
        end
        finish_packet();
    endtask

    task automatic test_directed();
        set_config(MAX_PAYLOAD_RESET, HS_ENABLE_RESET);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        send_byte(8'h09);
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h55);
        send_byte(8'hAA);
        send_var_packet(7'h0A, 16'd0);
        send_byte(8'h7F);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'hFF);
        send_handshake();
        send_var_packet(OP_HS_START, 16'd2);
        send_var_packet(7'h0A, 16'd3);
    endtask

    task automatic test_payload_limits();
        set_config(16'd0, 1'b1);
        send_var_packet(7'h0A, 16'd0);
        send_handshake();
        set_config(16'd3, 1'b0);
        send_var_packet(7'h22, 16'd3);
        send_var_packet(OP_HS_START, 16'd3);
        set_config(16'hFFFF, 1'b1);
        send_var_packet(7'h33, 16'd256);
        send_var_packet(7'h7F, 16'd0);
    endtask

    task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n,
                                       input logic [15:0] max_len, input logic hs_on);
        int start;
        set_config(max_len, hs_on);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
        start = bytes_sent;
        while (bytes_sent - start < n)
            send_random_packet();
    endtask

    task automatic test_backpressure();
        int start;
        set_config(MAX_PAYLOAD_RESET, 1'b1);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 300;
        start = bytes_sent;
        while (bytes_sent - start < 60)
            send_random_packet();
        quiesce();
        recv_stall_pct = 13;
        start = bytes_sent;
        while (bytes_sent - start < 40)
            send_random_packet();
    endtask

    task automatic test_stream_close();
        logic [15:0] max_len;
        logic [15:0] len;
        case ($urandom_range(2))
            0:
            begin
                set_config(MAX_PAYLOAD_RESET, 1'b1);
                case ($urandom_range(3))
                    0:       send_byte(8'h00);
                    1:       send_byte(8'h80);
                    2:       send_byte(8'hFF);
                    default: send_byte(8'($urandom_range(8'h81, 8'hFE)));
                endcase
            end
            1:
            begin
                max_len = 16'($urandom_range(0, 2000));
                set_config(max_len, 1'($urandom_range(1)));
                len = 16'($urandom_range(int'(max_len) + 1, 65535));
                send_byte($urandom_range(1) ? 8'h0A : 8'h7F);
                send_byte(len[15:8]);
                send_byte(len[7:0]);
            end
            default:
            begin
                set_config(16'($urandom_range(0, 16'hFF4F)), 1'b0);
                send_byte({1'b0, OP_HS_START});
                send_byte(HS_LEN_HI);
                send_byte(HS_LEN_LO);
            end
        endcase
        send_idle_pct = 13;
        recv_stall_pct = 13;
        repeat (30) send_byte(8'($urandom_range(255)));
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_payload_limits();
        test_random_traffic(0, 0, 280, MAX_PAYLOAD_RESET, 1'b1);
        test_random_traffic(81, 0, 280, 16'($urandom_range(1, 300)), 1'b0);
        test_random_traffic(0, 81, 280, 16'hFFFF, 1'b1);
        test_random_traffic(13, 13, 280, 16'($urandom_range(2, 40)),
                            1'($urandom_range(1)));
        test_backpressure();
        test_stream_close();
        quiesce();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("[opcode_length_packet_deframer_top] OK");
        else
            $display("[opcode_length_packet_deframer_top] ERROR");
        $finish;
    end

endmodule

[opcode_length_packet_deframer_top.f]
rtl/olpd_pkg.sv
rtl/olpd_front.sv
rtl/olpd_queue.sv
rtl/olpd_back.sv
rtl/opcode_length_packet_deframer_top.sv
test/tb_opcode_length_packet_deframer_top.sv
